// File: design/iot_pkg.sv
// Shared widths, action and order-kind codes, and default sizes for the order tracker.
package iot_pkg;

  localparam int ACTION_W = 2;
  localparam int QUEUE_W  = 6;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 32;

  localparam int QUEUE_COUNT_DEF = 64;
  localparam int LIST_DEPTH_DEF  = 16;

  localparam logic [ACTION_W-1:0] ACT_SET_MODE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CHECK    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELAXED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STRONG   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

  localparam logic MODE_ORDERED = 1'b0;

endpackage

// File: design/iot_in_if.sv
// Request channel of the order tracker: valid, ready and one request beat.
interface iot_in_if;
  logic                        valid;
  logic                        ready;
  logic [iot_pkg::ACTION_W-1:0] action;
  logic [iot_pkg::QUEUE_W-1:0]  queue_index;
  logic                        mode_value;
  logic [iot_pkg::KIND_W-1:0]   order_kind;
  logic [iot_pkg::ID_W-1:0]     request_id;

  modport source (
    output valid, action, queue_index, mode_value, order_kind, request_id,
    input  ready
  );

  modport sink (
    input  valid, action, queue_index, mode_value, order_kind, request_id,
    output ready
  );
endinterface

// File: design/iot_out_if.sv
// Result channel of the order tracker: valid, ready and one result beat.
interface iot_out_if;
  logic valid;
  logic ready;
  logic may_issue;
  logic list_empty_error;
  logic list_overflow;

  modport source (
    output valid, may_issue, list_empty_error, list_overflow,
    input  ready
  );

  modport sink (
    input  valid, may_issue, list_empty_error, list_overflow,
    output ready
  );
endinterface

// File: design/initiator_order_tracker_core.sv
// Order tracker core: per-queue mode and outstanding-id lists kept in two synchronous memories.
//
// Each request beat yields exactly one result beat. After reset the block clears its
// per-queue mode/count memory, one queue per cycle, and takes no request until every
// queue is cleared. Set mode, add and check go from acceptance to a result in the output
// register by reading the queue entry, updating it, and for a strong check reading the
// list head. A queue index at or above QUEUE_COUNT gives an all-zero result.
// Finish walks the current list of an ordered queue: the id memory has one read and one
// write port, and the search-and-compact walk reads one list entry per cycle, moving each
// entry after the match down by one slot as it goes. One request is in flight at a time;
// a new request is taken while a finished result still waits to be taken, and the next
// result waits in the engine until the output register frees up.
module initiator_order_tracker_core #(
  parameter int QUEUE_COUNT = iot_pkg::QUEUE_COUNT_DEF,
  parameter int LIST_DEPTH  = iot_pkg::LIST_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  iot_in_if.sink    req,
  iot_out_if.source rsp
);

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int ID_DEPTH = QUEUE_COUNT * LIST_DEPTH;
  localparam int AW = (ID_DEPTH > 1) ? $clog2(ID_DEPTH) : 1;
  localparam int CMP_W = 12;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_META  = 3'd2;
  localparam logic [2:0] ST_HEAD  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  typedef struct packed {
    logic          known;
    logic          ordered;
    logic [CW-1:0] count;
  } meta_t;

  meta_t                        meta_mem [QUEUE_COUNT];
  logic [iot_pkg::ID_W-1:0]     ids_mem  [ID_DEPTH];

  logic [2:0]                   state;
  logic [QW-1:0]                clr_idx;
  logic [QW-1:0]                q;
  logic [AW-1:0]                row_base;
  logic [iot_pkg::ACTION_W-1:0] action;
  logic                         mode_value;
  logic [iot_pkg::KIND_W-1:0]   order_kind;
  logic [iot_pkg::ID_W-1:0]     request_id;
  logic [CW-1:0]                cur_count;
  logic [IW-1:0]                scan_idx;
  logic                         found;
  logic                         res_may;
  logic                         res_err;
  logic                         res_ovf;
  logic                         out_valid;
  logic                         out_may;
  logic                         out_err;
  logic                         out_ovf;

  meta_t                        meta_rdata;
  logic [iot_pkg::ID_W-1:0]     ids_rdata;

  logic [QW-1:0]                meta_raddr;
  logic                         meta_we;
  logic [QW-1:0]                meta_waddr;
  meta_t                        meta_wdata;
  logic [AW-1:0]                ids_raddr;
  logic                         ids_we;
  logic [AW-1:0]                ids_waddr;
  logic [iot_pkg::ID_W-1:0]     ids_wdata;

  logic                         accept;
  logic                         in_range;
  logic                         out_free;
  logic                         ord_eff;
  logic                         add_rec;
  logic                         add_full;
  logic                         is_rs;
  logic                         hit;
  logic                         found_n;
  logic                         scan_last;

  assign accept    = req.valid & req.ready;
  assign in_range  = CMP_W'(req.queue_index) < CMP_W'(QUEUE_COUNT);
  assign out_free  = !out_valid || rsp.ready;
  assign is_rs     = (order_kind == iot_pkg::KIND_RELAXED) ||
                     (order_kind == iot_pkg::KIND_STRONG);
  assign ord_eff   = meta_rdata.known ? meta_rdata.ordered : 1'b1;
  assign add_rec   = ord_eff && is_rs;
  assign add_full  = meta_rdata.count >= CW'(LIST_DEPTH);
  assign hit       = !found && (ids_rdata == request_id);
  assign found_n   = found || hit;
  assign scan_last = CW'(scan_idx) == (cur_count - CW'(1));

  assign req.ready            = (state == ST_IDLE);
  assign rsp.valid            = out_valid;
  assign rsp.may_issue        = out_may;
  assign rsp.list_empty_error = out_err;
  assign rsp.list_overflow    = out_ovf;

  assign meta_raddr = QW'(req.queue_index);

  always_comb begin
    ids_raddr = row_base;
    if (state == ST_SCAN) begin
      ids_raddr = row_base + AW'(scan_idx) + AW'(1);
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = q;
    meta_wdata = meta_rdata;
    ids_we     = 1'b0;
    ids_waddr  = row_base + AW'(scan_idx) - AW'(1);
    ids_wdata  = ids_rdata;
    case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx;
        meta_wdata = '0;
      end
      ST_META: begin
        if (action == iot_pkg::ACT_SET_MODE) begin
          meta_we            = 1'b1;
          meta_wdata.known   = 1'b1;
          meta_wdata.ordered = (mode_value == iot_pkg::MODE_ORDERED);
        end else if (action == iot_pkg::ACT_ADD) begin
          meta_we            = 1'b1;
          meta_wdata.known   = 1'b1;
          meta_wdata.ordered = ord_eff;
          if (add_rec && !add_full) begin
            meta_wdata.count = meta_rdata.count + CW'(1);
            ids_we           = 1'b1;
            ids_waddr        = row_base + AW'(meta_rdata.count);
            ids_wdata        = request_id;
          end
        end
      end
      ST_SCAN: begin
        ids_we = found;
        if (scan_last && found_n) begin
          meta_we    = 1'b1;
          meta_wdata = '{known: 1'b1, ordered: 1'b1, count: cur_count - CW'(1)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    meta_rdata <= meta_mem[meta_raddr];
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
  end

  always_ff @(posedge clk) begin
    ids_rdata <= ids_mem[ids_raddr];
    if (ids_we) begin
      ids_mem[ids_waddr] <= ids_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + QW'(1);
          if (32'(clr_idx) == QUEUE_COUNT - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            q          <= QW'(req.queue_index);
            row_base   <= AW'(QW'(req.queue_index) * LIST_DEPTH);
            action     <= req.action;
            mode_value <= req.mode_value;
            order_kind <= req.order_kind;
            request_id <= req.request_id;
            res_may    <= 1'b0;
            res_err    <= 1'b0;
            res_ovf    <= 1'b0;
            state      <= in_range ? ST_META : ST_DONE;
          end
        end
        ST_META: begin
          state <= ST_DONE;
          case (action)
            iot_pkg::ACT_SET_MODE: begin
            end
            iot_pkg::ACT_ADD: begin
              res_ovf <= add_rec && add_full;
            end
            iot_pkg::ACT_FINISH: begin
              if (meta_rdata.known && meta_rdata.ordered && meta_rdata.count != '0) begin
                cur_count <= meta_rdata.count;
                scan_idx  <= '0;
                found     <= 1'b0;
                state     <= ST_SCAN;
              end
            end
            iot_pkg::ACT_CHECK: begin
              if (!meta_rdata.known) begin
                res_may <= 1'b0;
              end else if (!meta_rdata.ordered || !is_rs) begin
                res_may <= 1'b1;
              end else if (order_kind == iot_pkg::KIND_RELAXED) begin
                res_may <= 1'b1;
                res_err <= (meta_rdata.count == '0);
              end else if (meta_rdata.count == '0) begin
                res_may <= 1'b0;
                res_err <= 1'b1;
              end else begin
                state <= ST_HEAD;
              end
            end
            default: begin
            end
          endcase
        end
        ST_HEAD: begin
          res_may <= (ids_rdata == request_id);
          state   <= ST_DONE;
        end
        ST_SCAN: begin
          found <= found_n;
          if (scan_last) begin
            state <= ST_DONE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_may   <= res_may;
            out_err   <= res_err;
            out_ovf   <= res_ovf;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
